// File: hdl/first_fit_interval_reserver_assert.svh
// assertion macros shared by the reserver modules
`ifndef FIRST_FIT_INTERVAL_RESERVER_ASSERT_SVH
`define FIRST_FIT_INTERVAL_RESERVER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define FFIR_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FFIR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define FFIR_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define FFIR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// File: hdl/ffir_pkg.sv
package ffir_pkg;

   localparam int PEOPLE_W     = 8;
   localparam int REQ_TIME_W   = 16;
   localparam int CAP_W        = 8;
   localparam int ROOM_COUNT_W = 4;
   localparam int ROOM_INDEX_W = 3;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_INDEX_W  = 1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ROOM_COUNT      = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROOM_CAPACITIES = 1'b1;

   localparam logic [ROOM_COUNT_W-1:0] ROOM_COUNT_RESET = 4'd8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PICK,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_DONE
   } back_state_type;

endpackage

// File: hdl/ffir_front.sv
`include "first_fit_interval_reserver_assert.svh"

module ffir_front #(
   parameter int ROOMS     = 8,
   parameter int TIME_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [ffir_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ffir_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [ffir_pkg::PEOPLE_W-1:0]        req_people,
   input  logic [ffir_pkg::REQ_TIME_W-1:0]      req_start_time,
   input  logic [ffir_pkg::REQ_TIME_W-1:0]      req_end_time,
   output logic                                 q_valid,
   input  logic                                 q_pop,
   output logic [ROOMS-1:0]                     q_mask,
   output logic [TIME_BITS-1:0]                 q_start,
   output logic [TIME_BITS-1:0]                 q_end
);
   import ffir_pkg::*;

   localparam int QDEPTH = 2;

   logic [ROOM_COUNT_W-1:0]     room_count_ff;
   logic [CSR_DATA_W-1:0]       caps_ff;

   logic [ROOMS-1:0]            q_mask_ff  [QDEPTH];
   logic [TIME_BITS-1:0]        q_start_ff [QDEPTH];
   logic [TIME_BITS-1:0]        q_end_ff   [QDEPTH];
   logic                        wr_ptr_ff, wr_ptr_in;
   logic                        rd_ptr_ff, rd_ptr_in;
   logic [1:0]                  count_ff, count_in;

   logic                        push_ok;
   logic [ROOMS-1:0]            mask_new;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         room_count_ff <= ROOM_COUNT_RESET;
         caps_ff       <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ROOM_COUNT:      room_count_ff <= csr_wdata[ROOM_COUNT_W-1:0];
            CSR_ROOM_CAPACITIES: caps_ff       <= csr_wdata;
         endcase
      end
   end

   // classify: which rooms are in range and big enough
   always_comb begin
      for (int i = 0; i < ROOMS; i++) begin
         mask_new[i] = (room_count_ff > ROOM_COUNT_W'(i)) &&
                       (caps_ff[CAP_W*i +: CAP_W] >= req_people);
      end
   end

   assign req_full = (count_ff == 2'(QDEPTH));
   assign push_ok  = req_push && !req_full;
   assign q_valid  = (count_ff != 2'd0);
   assign q_mask   = q_mask_ff[rd_ptr_ff];
   assign q_start  = q_start_ff[rd_ptr_ff];
   assign q_end    = q_end_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (q_pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push_ok && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push_ok && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_mask_ff[wr_ptr_ff]  <= mask_new;
         q_start_ff[wr_ptr_ff] <= TIME_BITS'(req_start_time);
         q_end_ff[wr_ptr_ff]   <= TIME_BITS'(req_end_time);
      end
   end

   `FFIR_ASSERT_NEXT(a_q_full_holds, clock, reset, count_ff == 2'(QDEPTH) && !q_pop, count_ff == 2'(QDEPTH), "queue overflowed")

endmodule

// File: hdl/ffir_back.sv
`include "first_fit_interval_reserver_assert.svh"

module ffir_back #(
   parameter int ROOMS          = 8,
   parameter int SLOTS_PER_ROOM = 16,
   parameter int TIME_BITS      = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_valid,
   output logic                                 q_pop,
   input  logic [ROOMS-1:0]                     q_mask,
   input  logic [TIME_BITS-1:0]                 q_start,
   input  logic [TIME_BITS-1:0]                 q_end,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic                                 rsp_granted,
   output logic [ffir_pkg::ROOM_INDEX_W-1:0]    rsp_room_index
);
   import ffir_pkg::*;

   localparam int TOTAL  = ROOMS * SLOTS_PER_ROOM;
   localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int ROOM_W = (ROOMS > 1) ? $clog2(ROOMS) : 1;
   localparam int SLOT_W = (SLOTS_PER_ROOM > 1) ? $clog2(SLOTS_PER_ROOM) : 1;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS_PER_ROOM - 1);

   back_state_type              state_ff, state_in;
   logic [ROOMS-1:0]            mask_ff, mask_in;
   logic [TIME_BITS-1:0]        s_ff, s_in;
   logic [TIME_BITS-1:0]        e_ff, e_in;
   logic [ROOM_W-1:0]           room_ff, room_in;
   logic [SLOT_W-1:0]           slot_ff, slot_in;
   logic                        conflict_ff, conflict_in;
   logic                        found_ff, found_in;
   logic [SLOT_W-1:0]           free_ff, free_in;
   logic                        res_granted_ff, res_granted_in;
   logic [ROOM_INDEX_W-1:0]     res_room_ff, res_room_in;
   logic                        out_valid_ff, out_valid_in;
   logic                        out_granted_ff, out_granted_in;
   logic [ROOM_INDEX_W-1:0]     out_room_ff, out_room_in;

   // interval store and its read pipeline
   logic [2*TIME_BITS-1:0]      mem [TOTAL];
   logic [TOTAL-1:0]            used_ff;
   logic                        rd_en, wr_en;
   logic [ADDR_W-1:0]           base, rd_addr, wr_addr;
   logic                        rd_valid_ff;
   logic                        rd_used_ff;
   logic [SLOT_W-1:0]           rd_slot_ff;
   logic [2*TIME_BITS-1:0]      rd_data_ff;
   logic [TIME_BITS-1:0]        rd_beg, rd_fin;

   logic [ROOM_W-1:0]           low_room;

   assign base    = ADDR_W'(32'(room_ff) * SLOTS_PER_ROOM);
   assign rd_addr = base + ADDR_W'(slot_ff);
   assign wr_addr = base + ADDR_W'(free_ff);
   assign rd_beg  = rd_data_ff[2*TIME_BITS-1:TIME_BITS];
   assign rd_fin  = rd_data_ff[TIME_BITS-1:0];

   always_comb begin
      low_room = '0;
      for (int i = ROOMS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            low_room = ROOM_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {s_ff, e_ff};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_used_ff <= used_ff[rd_addr];
         rd_slot_ff <= slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_en;
         if (wr_en) begin
            used_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff        <= mask_in;
      s_ff           <= s_in;
      e_ff           <= e_in;
      room_ff        <= room_in;
      slot_ff        <= slot_in;
      conflict_ff    <= conflict_in;
      found_ff       <= found_in;
      free_ff        <= free_in;
      res_granted_ff <= res_granted_in;
      res_room_ff    <= res_room_in;
      out_granted_ff <= out_granted_in;
      out_room_ff    <= out_room_in;
   end

   always_comb begin
      state_in       = state_ff;
      mask_in        = mask_ff;
      s_in           = s_ff;
      e_in           = e_ff;
      room_in        = room_ff;
      slot_in        = slot_ff;
      conflict_in    = conflict_ff;
      found_in       = found_ff;
      free_in        = free_ff;
      res_granted_in = res_granted_ff;
      res_room_in    = res_room_ff;
      out_valid_in   = out_valid_ff;
      out_granted_in = out_granted_ff;
      out_room_in    = out_room_ff;
      q_pop          = 1'b0;
      rd_en          = 1'b0;
      wr_en          = 1'b0;

      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end

      // fold in one stored slot per cycle
      if (rd_valid_ff) begin
         if (rd_used_ff) begin
            if (s_ff < rd_fin && e_ff > rd_beg) begin
               conflict_in = 1'b1;
            end
         end else if (!found_ff) begin
            found_in = 1'b1;
            free_in  = rd_slot_ff;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               mask_in  = q_mask;
               s_in     = q_start;
               e_in     = q_end;
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (mask_ff == '0) begin
               res_granted_in = 1'b0;
               res_room_in    = '0;
               state_in       = ST_DONE;
            end else begin
               room_in     = low_room;
               mask_in     = mask_ff & (mask_ff - ROOMS'(1));
               slot_in     = '0;
               conflict_in = 1'b0;
               found_in    = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_en = 1'b1;
            if (slot_ff == SLOT_LAST) begin
               state_in = ST_DRAIN;
            end else begin
               slot_in = slot_ff + SLOT_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!conflict_ff && found_ff) begin
               wr_en          = 1'b1;
               res_granted_in = 1'b1;
               res_room_in    = ROOM_INDEX_W'(room_ff);
               state_in       = ST_DONE;
            end else begin
               state_in = ST_PICK;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in   = 1'b1;
               out_granted_in = res_granted_ff;
               out_room_in    = res_room_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_granted    = out_granted_ff;
   assign rsp_room_index = out_room_ff;

   `FFIR_ASSERT_NEXT(a_scan_feeds_pipe, clock, reset, state_ff == ST_SCAN, rd_valid_ff, "read pipe lost a beat")
   `FFIR_ASSERT_IMPL(a_write_free_slot, clock, reset, wr_en, !used_ff[wr_addr], "grant overwrote a used slot")
   `FFIR_ASSERT_IMPL(a_denied_room_zero, clock, reset, out_valid_ff && !out_granted_ff, out_room_ff == '0, "denied result carries a room")

endmodule

// File: hdl/first_fit_interval_reserver.sv
// channel   direction  handshake                 fields
// req       in         push / full               people, start_time, end_time
// rsp       out        empty / pop               granted, room_index
// csr       in         write_en, no wait         index, wdata
//
// a request scans each room that passes the capacity check, lowest first, until one grants or none
// is left; the scan reads one slot a cycle through the single read port of the interval memory
// reset is synchronous and active high; it clears all slots at once (used flags in flops)
// a two-beat queue sits between classify and scan, and one result register at the output,
// so a waiting result holds up the back only when the next result is ready to take its place
module first_fit_interval_reserver #(
   parameter int ROOMS          = 8,
   parameter int SLOTS_PER_ROOM = 16,
   parameter int TIME_BITS      = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [ffir_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ffir_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [ffir_pkg::PEOPLE_W-1:0]        req_people,
   input  logic [ffir_pkg::REQ_TIME_W-1:0]      req_start_time,
   input  logic [ffir_pkg::REQ_TIME_W-1:0]      req_end_time,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic                                 rsp_granted,
   output logic [ffir_pkg::ROOM_INDEX_W-1:0]    rsp_room_index
);
   import ffir_pkg::*;

   // classified beats between front and back
   logic                   q_valid;
   logic                   q_pop;
   logic [ROOMS-1:0]       q_mask;
   logic [TIME_BITS-1:0]   q_start;
   logic [TIME_BITS-1:0]   q_end;

   // front: config registers, capacity/range check, request queue
   ffir_front #(
      .ROOMS     (ROOMS),
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_people     (req_people),
      .req_start_time (req_start_time),
      .req_end_time   (req_end_time),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_mask         (q_mask),
      .q_start        (q_start),
      .q_end          (q_end)
   );

   // back: per-room slot scan, overlap check, commit, result register
   ffir_back #(
      .ROOMS          (ROOMS),
      .SLOTS_PER_ROOM (SLOTS_PER_ROOM),
      .TIME_BITS      (TIME_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_mask         (q_mask),
      .q_start        (q_start),
      .q_end          (q_end),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_granted    (rsp_granted),
      .rsp_room_index (rsp_room_index)
   );

endmodule

// File: dv/tb_top.sv
module tb_top;
   import ffir_pkg::*;

   localparam int ROOM_TOTAL   = 8;
   localparam int SLOT_DEPTH   = 16;
   localparam int SLOT_TOTAL   = ROOM_TOTAL * SLOT_DEPTH;
   localparam int PHASES       = 10;
   localparam int PHASE_BEATS  = 55;
   // covers the longest scan of each request, plus the longest gap on each side
   localparam int LIMIT_CYCLES = 1_200_000;

   // room counts per random phase: zero, above the room total and the full range
   localparam logic [ROOM_COUNT_W-1:0] PHASE_ROOMS [PHASES] =
      '{4'd1, 4'd2, 4'd0, 4'd3, 4'd15, 4'd4, 4'd6, 4'd8, 4'd10, 4'd5};

   typedef struct packed {
      logic                    granted;
      logic [ROOM_INDEX_W-1:0] room;
   } booking_type;

   // mirror of the interval store plus the responses still owed
   class reservation_book_type;
      logic [ROOM_COUNT_W-1:0] room_count;
      logic [CSR_DATA_W-1:0]   capacities;
      bit                      used      [SLOT_TOTAL];
      logic [REQ_TIME_W-1:0]   slot_from [SLOT_TOTAL];
      logic [REQ_TIME_W-1:0]   slot_to   [SLOT_TOTAL];
      booking_type             expected[$];
      int                      mismatches;

      function new();
         room_count = ROOM_COUNT_RESET;
         capacities = '0;
         mismatches = 0;
         foreach (used[i]) used[i] = 1'b0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_ROOM_COUNT:      room_count = value[ROOM_COUNT_W-1:0];
            CSR_ROOM_CAPACITIES: capacities = value;
            default: ;
         endcase
      endfunction

      // first room with enough seats, no clash and a free slot wins
      function void note_request(logic [PEOPLE_W-1:0] people, logic [REQ_TIME_W-1:0] s,
                                 logic [REQ_TIME_W-1:0] e);
         booking_type want;
         int          limit;
         int          slot;
         int          idx;
         bit          clash;
         want  = '0;
         limit = (room_count > ROOM_TOTAL) ? ROOM_TOTAL : int'(room_count);
         for (int r = 0; r < limit && !want.granted; r++) begin
            if (capacities[8*r +: 8] < people) continue;
            slot  = -1;
            clash = 1'b0;
            for (int k = 0; k < SLOT_DEPTH; k++) begin
               idx = r * SLOT_DEPTH + k;
               if (used[idx]) begin
                  if (s < slot_to[idx] && e > slot_from[idx]) clash = 1'b1;
               end else if (slot < 0) begin
                  slot = k;
               end
            end
            if (clash || slot < 0) continue;
            idx            = r * SLOT_DEPTH + slot;
            used[idx]      = 1'b1;
            slot_from[idx] = s;
            slot_to[idx]   = e;
            want.granted   = 1'b1;
            want.room      = ROOM_INDEX_W'(r);
         end
         expected.push_back(want);
      endfunction

      function void flag(string what, int want, int got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
      endfunction

      function void check_result(logic granted, logic [ROOM_INDEX_W-1:0] room);
         booking_type want;
         if (expected.size() == 0) begin
            flag("unrequested beat, granted", 0, granted);
            return;
         end
         want = expected.pop_front();
         if (granted !== want.granted) flag("granted", want.granted, granted);
         if (room !== want.room) flag("room_index", want.room, room);
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_write_en;
   logic [CSR_INDEX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]     csr_wdata;
   logic                      req_push;
   logic                      req_full;
   logic [PEOPLE_W-1:0]       req_people;
   logic [REQ_TIME_W-1:0]     req_start_time;
   logic [REQ_TIME_W-1:0]     req_end_time;
   logic                      rsp_empty;
   logic                      rsp_pop;
   logic                      rsp_granted;
   logic [ROOM_INDEX_W-1:0]   rsp_room_index;

   reservation_book_type board = new();

   first_fit_interval_reserver dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_people     (req_people),
      .req_start_time (req_start_time),
      .req_end_time   (req_end_time),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_granted    (rsp_granted),
      .rsp_room_index (rsp_room_index)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // mostly no gap, some short ones, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 90);
   endfunction

   // one request beat; push stays high afterwards so back-to-back beats need no toggle
   task automatic send_request(input logic [PEOPLE_W-1:0] people,
                               input logic [REQ_TIME_W-1:0] s, input logic [REQ_TIME_W-1:0] e);
      @(negedge clock);
      req_push       <= 1'b1;
      req_people     <= people;
      req_start_time <= s;
      req_end_time   <= e;
      @(posedge clock);
      while (req_full) @(posedge clock);
      board.note_request(people, s, e);
   endtask

   task automatic hold_off(input int cycles);
      @(negedge clock);
      req_push <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // sender goes quiet until every owed response has been popped
   task automatic wait_idle();
      @(negedge clock);
      req_push <= 1'b0;
      while (board.expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      board.set_register(idx, value);
   endtask

   // half the beats sit in a narrow time window so clashes are common;
   // the rest are wide random, empty, reversed or at the time extremes
   task automatic random_request();
      logic [PEOPLE_W-1:0]   people;
      logic [REQ_TIME_W-1:0] s;
      logic [REQ_TIME_W-1:0] e;
      int                    pick;
      if ($urandom_range(0, 9) < 3) people = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else people = PEOPLE_W'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      s    = REQ_TIME_W'($urandom_range(0, 4000));
      if (pick < 50) begin
         e = s + REQ_TIME_W'($urandom_range(1, 300));
      end else if (pick < 75) begin
         s = REQ_TIME_W'($urandom);
         e = REQ_TIME_W'($urandom);
      end else if (pick < 85) begin
         e = s;
      end else if (pick < 95) begin
         e = s - REQ_TIME_W'($urandom_range(1, 300));
      end else begin
         s = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         e = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
      send_request(people, s, e);
   endtask

   // response side: random pop stalls with bursts of steady popping
   initial begin : result_drain
      int stall;
      int calm;
      stall = 0;
      calm  = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            stall--;
         end else begin
            rsp_pop <= 1'b1;
            if (calm > 0) calm--;
            else if ($urandom_range(0, 15) == 0) calm = $urandom_range(30, 200);
            else stall = pick_gap();
         end
      end
   end

   // every popped response beat is compared with the oldest owed one
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) board.check_result(rsp_granted, rsp_room_index);
   end

   initial begin : watchdog
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] caps;
      int                    gap;
      bit                    sender_calm;
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_index      = CSR_ROOM_COUNT;
      csr_wdata      = '0;
      req_push       = 1'b0;
      req_people     = '0;
      req_start_time = '0;
      req_end_time   = '0;
      rsp_pop        = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: all eight rooms with zero seats
      send_request(8'd0, 16'd0, 16'd100);     // zero people fits a zero-seat room
      send_request(8'd1, 16'd0, 16'd100);     // one person fits nowhere
      send_request(8'd0, 16'd50, 16'd150);    // clashes in room 0, goes to room 1
      wait_idle();

      // room count zero: nothing scanned
      write_csr(CSR_ROOM_COUNT, 64'd0);
      write_csr(CSR_ROOM_CAPACITIES, '1);
      send_request(8'd0, 16'd1000, 16'd2000);
      wait_idle();

      // room count above the room total, rising capacities
      write_csr(CSR_ROOM_COUNT, {60'hFFFF_FFFF_FFFF_FFF, 4'd15});
      write_csr(CSR_ROOM_CAPACITIES, 64'hFF80_4020_1008_0401);
      send_request(8'd255, 16'd0, 16'hFFFF);      // only the last room seats 255
      send_request(8'd255, 16'hFFFF, 16'hFFFF);   // empty interval at the top end
      send_request(8'd255, 16'd100, 16'd10);      // reversed, clashes with the full span
      send_request(8'd200, 16'hFFFF, 16'h0000);   // reversed at the extremes
      send_request(8'd1, 16'd0, 16'd0);           // empty interval at zero
      send_request(8'd2, 16'd0, 16'd1);
      send_request(8'd128, 16'd200, 16'd300);
      send_request(8'd129, 16'd200, 16'd300);
      send_request(8'd0, 16'd0, 16'hFFFF);
      send_request(8'd33, 16'd5000, 16'd5001);
      send_request(8'd64, 16'd5000, 16'd5001);
      send_request(8'd0, 16'hFFFE, 16'hFFFF);

      // random phases, each with its own settings; tables fill up along the way
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         for (int b = 0; b < ROOM_TOTAL; b++) begin
            case ($urandom_range(0, 3))
               0:       caps[8*b +: 8] = 8'h00;
               1:       caps[8*b +: 8] = 8'hFF;
               default: caps[8*b +: 8] = 8'($urandom_range(0, 255));
            endcase
         end
         if (phase == 3) caps = '0;
         if (phase == 5) caps = '1;
         write_csr(CSR_ROOM_COUNT, {$urandom, 28'($urandom), PHASE_ROOMS[phase]});
         write_csr(CSR_ROOM_CAPACITIES, caps);
         sender_calm = (phase % 3 == 1);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            random_request();
            if (!sender_calm) begin
               gap = pick_gap();
               if (gap > 0) hold_off(gap);
            end
            if ($urandom_range(0, 39) == 0) wait_idle();
         end
      end

      wait_idle();
      repeat (200) @(posedge clock);
      if (board.mismatches == 0 && board.expected.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+hdl
hdl/ffir_pkg.sv
hdl/ffir_front.sv
hdl/ffir_back.sv
hdl/first_fit_interval_reserver.sv
dv/tb_top.sv
